>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk_i outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/rhic_pkg.sv
// ----------------------------------------------------------------------------
// rhic_pkg
// Codes, defaults and the sequencer state type of the Hilbert index converter.
// ----------------------------------------------------------------------------
package rhic_pkg;

  localparam int COORD_BITS_DEFAULT = 16;

  localparam logic OP_TO_CELL  = 1'b0;
  localparam logic OP_TO_INDEX = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam int GRID_RESET = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_RANGE,
    ST_LEVEL,
    ST_MUL,
    ST_CMP,
    ST_LEAF
  } state_e;

endpackage

>>> rtl/rect_hilbert_index_converter.sv
// ----------------------------------------------------------------------------
// rect_hilbert_index_converter
// Generalized Hilbert curve on a rectangular grid: index to cell and back.
// ----------------------------------------------------------------------------
// Sequence: ST_AREA forms the grid area, ST_RANGE checks the input and loads a
//   range error. Each split level forms its children in ST_LEVEL and tests them
//   in turn in ST_MUL and ST_CMP on the shared multiplier and accumulator, the
//   last untested; ST_LEAF walks the final strip and loads the result. A stalled
//   output holds ST_RANGE or ST_LEAF. One transaction at a time: a new one is
//   taken once the sequencer is idle again. Reset (rst_ni low, asynchronous)
//   returns to idle, empties the output register, sets both grid sizes to 256.
module rect_hilbert_index_converter #(
  parameter int COORD_BITS = rhic_pkg::COORD_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] curve_index_i,
  input  logic [15:0] cell_x_i,
  input  logic [15:0] cell_y_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [31:0] out_index_o,
  output logic [1:0]  status_o
);

  `include "assert_macros.svh"

  // Bits kept of a written size, and the width of the stored sizes. The stored
  // width never drops below what the reset size of 256 needs.
  localparam int VB     = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int GRID_W = (VB < 9) ? 9 : VB;
  // Signed coordinate width: room for a negative axis vector of full length.
  localparam int XW     = GRID_W + 2;
  localparam int AW     = 2 * GRID_W;
  localparam logic [15:0] CFG_MASK = 16'((32'd1 << VB) - 32'd1);

  // One rectangle of the descent: a start corner plus a major axis a and a
  // minor axis b. Exactly one component of each axis is nonzero.
  typedef struct packed {
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [XW-1:0] ax;
    logic signed [XW-1:0] ay;
    logic signed [XW-1:0] bx;
    logic signed [XW-1:0] by;
  } rect_t;

  function automatic logic [GRID_W-1:0] f_abs(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = v[XW-1] ? -v : v;
    return t[GRID_W-1:0];
  endfunction

  function automatic logic signed [XW-1:0] f_sgn(input logic signed [XW-1:0] v);
    if (v[XW-1]) begin
      return '1;
    end else if (v != '0) begin
      return XW'(1);
    end else begin
      return '0;
    end
  endfunction

  // True when the cell lies in the exact box of cells that the rectangle covers.
  function automatic logic f_inbox(input rect_t c, input logic signed [XW-1:0] px,
                                   input logic signed [XW-1:0] py);
    logic signed [XW-1:0] ex;
    logic signed [XW-1:0] ey;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] x1;
    logic signed [XW-1:0] y0;
    logic signed [XW-1:0] y1;
    ex = c.sx + (c.ax - f_sgn(c.ax)) + (c.bx - f_sgn(c.bx));
    ey = c.sy + (c.ay - f_sgn(c.ay)) + (c.by - f_sgn(c.by));
    x0 = (c.sx < ex) ? c.sx : ex;
    x1 = (c.sx < ex) ? ex : c.sx;
    y0 = (c.sy < ey) ? c.sy : ey;
    y1 = (c.sy < ey) ? ey : c.sy;
    return (px >= x0) && (px <= x1) && (py >= y0) && (py <= y1);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  rhic_pkg::state_e state_q, state_d;

  logic [GRID_W-1:0] grid_w_q, grid_h_q;
  logic              op_q, op_d;
  logic              cell_err_q, cell_err_d;
  logic [GRID_W-1:0] px_q, px_d, py_q, py_d;
  // Accumulator: the remaining index when mapping to a cell, the index built
  // so far when mapping to an index.
  logic [31:0]       acc_q, acc_d;
  rect_t             r_q, r_d;
  rect_t             ch0_q, ch0_d, ch1_q, ch1_d, ch2_q, ch2_d;
  // Children still to test before the last one, which is taken without a test.
  logic [1:0]        cnt_q, cnt_d;
  logic [AW-1:0]     prod_q, prod_d;
  logic              inbox_q, inbox_d;

  logic              out_valid_q, out_valid_d;
  logic [15:0]       out_x_q, out_x_d, out_y_q, out_y_d;
  logic [31:0]       out_index_q, out_index_d;
  logic [1:0]        status_q, status_d;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_accept;
  logic out_free;

  assign in_stall_o = (state_q != rhic_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Split of the current rectangle into two or three children
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] dax, day, dbx, dby, a2x, a2y, b2x, b2y;
  logic [GRID_W-1:0]    rw, rh, w2, h2;
  logic [GRID_W+1:0]    w_x2, h_x3;
  logic                 horiz;
  logic                 leaf;
  rect_t                c0, c1, c2;

  always_comb begin
    dax = f_sgn(r_q.ax);
    day = f_sgn(r_q.ay);
    dbx = f_sgn(r_q.bx);
    dby = f_sgn(r_q.by);
    rw  = f_abs(r_q.ax + r_q.ay);
    rh  = f_abs(r_q.bx + r_q.by);
    // Arithmetic shift gives the floor half for both signs.
    a2x = r_q.ax >>> 1;
    a2y = r_q.ay >>> 1;
    b2x = r_q.bx >>> 1;
    b2y = r_q.by >>> 1;
    w2  = f_abs(a2x + a2y);
    h2  = f_abs(b2x + b2y);
    w_x2  = {1'b0, rw, 1'b0};
    h_x3  = {2'b00, rh} + {1'b0, rh, 1'b0};
    horiz = (w_x2 > h_x3);
    leaf  = (rw == GRID_W'(1)) || (rh == GRID_W'(1));

    if (horiz) begin
      // Two halves along the major axis, the first kept even where possible.
      if (w2[0] && (rw > GRID_W'(2))) begin
        a2x = a2x + dax;
        a2y = a2y + day;
      end
      c0 = '{sx: r_q.sx, sy: r_q.sy, ax: a2x, ay: a2y, bx: r_q.bx, by: r_q.by};
      c1 = '{sx: r_q.sx + a2x, sy: r_q.sy + a2y, ax: r_q.ax - a2x, ay: r_q.ay - a2y,
             bx: r_q.bx, by: r_q.by};
      c2 = c1;
    end else begin
      // Up the minor half, across the long side, then back down.
      if (h2[0] && (rh > GRID_W'(2))) begin
        b2x = b2x + dbx;
        b2y = b2y + dby;
      end
      c0 = '{sx: r_q.sx, sy: r_q.sy, ax: b2x, ay: b2y, bx: a2x, by: a2y};
      c1 = '{sx: r_q.sx + b2x, sy: r_q.sy + b2y, ax: r_q.ax, ay: r_q.ay,
             bx: r_q.bx - b2x, by: r_q.by - b2y};
      c2 = '{sx: r_q.sx + (r_q.ax - dax) + (b2x - dbx),
             sy: r_q.sy + (r_q.ay - day) + (b2y - dby),
             ax: -b2x, ay: -b2y, bx: -(r_q.ax - a2x), by: -(r_q.ay - a2y)};
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and box test. The whole grid is the source in ST_AREA,
  // for the range check; during the descent it is the child under test.
  // --------------------------------------------------------------------------
  rect_t                mul_src;
  logic [GRID_W-1:0]    mul_w, mul_h;
  logic signed [XW-1:0] px_s, py_s;

  assign px_s = {2'b00, px_q};
  assign py_s = {2'b00, py_q};

  always_comb begin
    mul_src = (state_q == rhic_pkg::ST_AREA) ? r_q : ch0_q;
    mul_w   = f_abs(mul_src.ax + mul_src.ay);
    mul_h   = f_abs(mul_src.bx + mul_src.by);
  end

  // --------------------------------------------------------------------------
  // Shared accumulator adder: subtracts the area for index-to-cell, adds it
  // for cell-to-index. The carry out of the subtraction means acc >= area.
  // --------------------------------------------------------------------------
  logic [31:0] prod32;
  logic [31:0] addend;
  logic [32:0] sum33;
  logic        acc_ge;
  logic        hit;

  always_comb begin
    prod32 = 32'(prod_q);
    addend = (op_q == rhic_pkg::OP_TO_INDEX) ? prod32 : ~prod32;
    sum33  = {1'b0, acc_q} + {1'b0, addend} +
             {32'd0, (op_q == rhic_pkg::OP_TO_CELL)};
    acc_ge = sum33[32];
    hit    = (op_q == rhic_pkg::OP_TO_CELL) ? !acc_ge : inbox_q;
  end

  // --------------------------------------------------------------------------
  // Strip walk at the end of the descent
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] d_s, dir_x, dir_y, step_x, step_y, fx, fy;
  logic [GRID_W:0]      walk_len;
  logic [15:0]          fx16, fy16;
  logic [31:0]          idx_fin;
  logic                 range_err;

  always_comb begin
    d_s   = {2'b00, acc_q[GRID_W-1:0]};
    // A strip one cell high runs along a, otherwise along b.
    dir_x = (rh == GRID_W'(1)) ? dax : dbx;
    dir_y = (rh == GRID_W'(1)) ? day : dby;
    step_x = dir_x[XW-1] ? -d_s : ((dir_x != '0) ? d_s : '0);
    step_y = dir_y[XW-1] ? -d_s : ((dir_y != '0) ? d_s : '0);
    fx = r_q.sx + step_x;
    fy = r_q.sy + step_y;
    fx16 = '0;
    fy16 = '0;
    fx16[GRID_W-1:0] = fx[GRID_W-1:0];
    fy16[GRID_W-1:0] = fy[GRID_W-1:0];
    walk_len = {1'b0, f_abs(px_s - r_q.sx)} + {1'b0, f_abs(py_s - r_q.sy)};
    idx_fin = acc_q + 32'(walk_len);
    range_err = (op_q == rhic_pkg::OP_TO_CELL) ? acc_ge : cell_err_q;
  end

  // Cell test against the grid, made on the raw input fields at acceptance.
  logic [15:0] grid_w16, grid_h16;

  always_comb begin
    grid_w16 = '0;
    grid_h16 = '0;
    grid_w16[GRID_W-1:0] = grid_w_q;
    grid_h16[GRID_W-1:0] = grid_h_q;
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rhic_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = rhic_pkg::ST_AREA;
        end
      end
      rhic_pkg::ST_AREA: begin
        state_d = rhic_pkg::ST_RANGE;
      end
      rhic_pkg::ST_RANGE: begin
        if (!range_err) begin
          state_d = rhic_pkg::ST_LEVEL;
        end else if (out_free) begin
          state_d = rhic_pkg::ST_IDLE;
        end
      end
      rhic_pkg::ST_LEVEL: begin
        state_d = leaf ? rhic_pkg::ST_LEAF : rhic_pkg::ST_MUL;
      end
      rhic_pkg::ST_MUL: begin
        state_d = rhic_pkg::ST_CMP;
      end
      rhic_pkg::ST_CMP: begin
        if (hit || (cnt_q == 2'd1)) begin
          state_d = rhic_pkg::ST_LEVEL;
        end else begin
          state_d = rhic_pkg::ST_MUL;
        end
      end
      rhic_pkg::ST_LEAF: begin
        if (out_free) begin
          state_d = rhic_pkg::ST_IDLE;
        end
      end
      default: state_d = rhic_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath and output register updates
  // --------------------------------------------------------------------------
  always_comb begin
    op_d        = op_q;
    cell_err_d  = cell_err_q;
    px_d        = px_q;
    py_d        = py_q;
    acc_d       = acc_q;
    r_d         = r_q;
    ch0_d       = ch0_q;
    ch1_d       = ch1_q;
    ch2_d       = ch2_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    inbox_d     = inbox_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_index_d = out_index_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      rhic_pkg::ST_IDLE: begin
        if (in_accept) begin
          op_d       = opcode_i;
          cell_err_d = (cell_x_i >= grid_w16) || (cell_y_i >= grid_h16);
          px_d       = cell_x_i[GRID_W-1:0];
          py_d       = cell_y_i[GRID_W-1:0];
          acc_d      = (opcode_i == rhic_pkg::OP_TO_CELL) ? curve_index_i : '0;
          r_d        = '{sx: '0, sy: '0, ax: {2'b00, grid_w_q}, ay: '0,
                         bx: '0, by: {2'b00, grid_h_q}};
        end
      end
      rhic_pkg::ST_AREA: begin
        prod_d = {{GRID_W{1'b0}}, mul_w} * {{GRID_W{1'b0}}, mul_h};
      end
      rhic_pkg::ST_RANGE: begin
        if (range_err && out_free) begin
          out_valid_d = 1'b1;
          out_x_d     = '0;
          out_y_d     = '0;
          out_index_d = '0;
          status_d    = (op_q == rhic_pkg::OP_TO_CELL) ? rhic_pkg::STATUS_RANGE
                                                       : rhic_pkg::STATUS_OUTSIDE;
        end
      end
      rhic_pkg::ST_LEVEL: begin
        if (!leaf) begin
          ch0_d = c0;
          ch1_d = c1;
          ch2_d = c2;
          cnt_d = horiz ? 2'd1 : 2'd2;
        end
      end
      rhic_pkg::ST_MUL: begin
        prod_d  = {{GRID_W{1'b0}}, mul_w} * {{GRID_W{1'b0}}, mul_h};
        inbox_d = f_inbox(ch0_q, px_s, py_s);
      end
      rhic_pkg::ST_CMP: begin
        if (hit) begin
          r_d = ch0_q;
        end else begin
          acc_d = sum33[31:0];
          cnt_d = cnt_q - 2'd1;
          if (cnt_q == 2'd1) begin
            r_d = ch1_q;
          end else begin
            ch0_d = ch1_q;
            ch1_d = ch2_q;
          end
        end
      end
      rhic_pkg::ST_LEAF: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = rhic_pkg::STATUS_OK;
          if (op_q == rhic_pkg::OP_TO_CELL) begin
            out_x_d     = fx16;
            out_y_d     = fy16;
            out_index_d = '0;
          end else begin
            out_x_d     = '0;
            out_y_d     = '0;
            out_index_d = idx_fin;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rhic_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      grid_w_q    <= GRID_W'(rhic_pkg::GRID_RESET);
      grid_h_q    <= GRID_W'(rhic_pkg::GRID_RESET);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rhic_pkg::CFG_GRID_WIDTH:  grid_w_q <= GRID_W'(cfg_wdata_i & CFG_MASK);
          rhic_pkg::CFG_GRID_HEIGHT: grid_h_q <= GRID_W'(cfg_wdata_i & CFG_MASK);
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    cell_err_q  <= cell_err_d;
    px_q        <= px_d;
    py_q        <= py_d;
    acc_q       <= acc_d;
    r_q         <= r_d;
    ch0_q       <= ch0_d;
    ch1_q       <= ch1_d;
    ch2_q       <= ch2_d;
    prod_q      <= prod_d;
    inbox_q     <= inbox_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_index_q <= out_index_d;
    status_q    <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_index_o = out_index_q;
  assign status_o    = status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_accept_starts, (in_valid_i && !in_stall_o) |=> (state_q == rhic_pkg::ST_AREA), "accepted transaction did not start the sequencer")
  `ASSERT_IMPLY(a_child_pending, (state_q == rhic_pkg::ST_MUL) || (state_q == rhic_pkg::ST_CMP), cnt_q != 2'd0, "child test with no child left to test")
  `ASSERT_IMPLY(a_leaf_is_strip, state_q == rhic_pkg::ST_LEAF, (rw == GRID_W'(1)) || (rh == GRID_W'(1)), "strip walk on a rectangle wider than one cell")
  `ASSERT_IMPLY(a_error_zero, out_valid_q && (status_q != rhic_pkg::STATUS_OK), (out_x_q == '0) && (out_y_q == '0) && (out_index_q == '0), "error result carries nonzero payload")

endmodule
